// ----- rtl/core/pciq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pciq_pkg
// Shared constants, codes and controller/datapath types for the pedal
// control input qualifier.
// ----------------------------------------------------------------------------
package pciq_pkg;

   localparam int SAMPLE_BITS_DEF  = 12;
   localparam int WARMUP_TICKS_DEF = 200;

   localparam int VALUE_BITS     = 16;
   localparam int LEVEL_BITS     = 13;
   localparam int MODE_BITS      = 3;
   localparam int PHASE_BITS     = 3;
   localparam int STABLE_BITS    = 4;
   localparam int WARM_BITS      = 8;
   localparam int LED_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Operating modes
   localparam logic [MODE_BITS-1:0] MODE_OFF    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_POT    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_SEL    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_TOGGLE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MOM    = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_TAP    = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVELS    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERTED  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMPO_MIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMPO_MAX = 3'd4;

   // LED commands
   localparam logic [LED_BITS-1:0] LED_NONE  = 2'd0;
   localparam logic [LED_BITS-1:0] LED_ON    = 2'd1;
   localparam logic [LED_BITS-1:0] LED_BLINK = 2'd2;

   // Button and tap phases
   localparam logic [PHASE_BITS-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_DOWN    = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_HELD    = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_ARMED   = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_SETTLE  = 3'd4;

   localparam logic [STABLE_BITS-1:0] STABLE_BUTTON = 4'd2;
   localparam logic [STABLE_BITS-1:0] STABLE_TAP    = 4'd10;
   localparam logic [VALUE_BITS-1:0]  BLINK_ON      = 16'd10;

   typedef struct packed {
      logic load_sample;
      logic start_inc;
      logic latch_inc;
      logic start_pos;
      logic update;
   } pciq_cmd_type;

   typedef struct packed {
      logic need_div;
      logic inc_valid;
      logic div_done;
      logic rsp_busy;
   } pciq_status_type;

   function automatic logic [VALUE_BITS-1:0] off_time(input logic [VALUE_BITS-1:0] interval);
      return (interval > BLINK_ON) ? interval - BLINK_ON : '0;
   endfunction

endpackage

// ----- rtl/core/pciq_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pciq channel interfaces
// Sample request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pciq_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface pciq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic        changed;
   logic        unsaved_changes;
   logic [1:0]  led_action;
   logic [15:0] led_off_time;

   modport source (output valid, output value, output changed, output unsaved_changes,
                   output led_action, output led_off_time, input ready);
   modport sink   (input valid, input value, input changed, input unsaved_changes,
                   input led_action, input led_off_time, output ready);
endinterface

interface pciq_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/pciq_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pciq_div
// Restoring divider, one quotient bit per cycle. done is high in the cycle of
// the last step; quotient and remainder are valid from the next cycle on.
// ----------------------------------------------------------------------------
module pciq_div #(
   parameter int WIDTH = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH:0]   trial;
   logic             fits;
   logic             last;

   assign trial = {rem_ff, num_ff[WIDTH-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign last  = cnt_ff == CW'(WIDTH - 1);
   assign done  = busy_ff && last;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[WIDTH-2:0], fits};
         rem_in = fits ? WIDTH'(trial - {1'b0, den_ff}) : trial[WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/pciq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pciq_datapath
// Registers, sample capture, quantizer divider and per-mode update logic.
// ----------------------------------------------------------------------------
module pciq_datapath import pciq_pkg::*; #(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int WARMUP_TICKS = WARMUP_TICKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  pciq_cmd_type           cmd,
   output pciq_status_type        status,
   pciq_csr_if.sink               csr_if,
   pciq_rsp_if.source             rsp_if
);

   localparam int DW   = SAMPLE_BITS + 1;
   localparam int CMPW = (DW > LEVEL_BITS) ? DW : LEVEL_BITS;
   localparam logic [WARM_BITS-1:0]   WARM_LIMIT = WARM_BITS'(WARMUP_TICKS);
   localparam logic [SAMPLE_BITS-1:0] HALF = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   // configuration
   logic [MODE_BITS-1:0]  mode_ff;
   logic [LEVEL_BITS-1:0] levels_ff;
   logic                  inverted_ff;
   logic [VALUE_BITS-1:0] tempo_min_ff;
   logic [VALUE_BITS-1:0] tempo_max_ff;

   // channel state
   logic [VALUE_BITS-1:0]  cv_ff, cv_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [STABLE_BITS-1:0] stable_ff, stable_in;
   logic [VALUE_BITS-1:0]  tap_ff, tap_in;
   logic [WARM_BITS-1:0]   warm_ff, warm_in;
   logic                   unsaved_ff, unsaved_in;

   logic [SAMPLE_BITS-1:0] s_ff;
   logic [DW-1:0]          inc_ff;
   logic                   inc_valid_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_changed_ff;
   logic                  rsp_unsaved_ff;
   logic [LED_BITS-1:0]   rsp_led_ff;
   logic [VALUE_BITS-1:0] rsp_off_ff;

   logic                  changed_in;
   logic [LED_BITS-1:0]   led_in;
   logic [VALUE_BITS-1:0] off_in;

   // quantizer
   logic [CMPW-1:0] lc_ext, span_ext;
   logic [DW-1:0]   lc_eff;
   logic            div_start, div_done;
   logic [DW-1:0]   div_dividend, div_divisor, div_quot, div_rem;
   logic [DW-1:0]   pos;
   logic [VALUE_BITS-1:0] pos16;
   logic [DW-1:0]   quarter;
   logic            press, release_s;
   logic            csr_write;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   assign lc_ext   = CMPW'(levels_ff);
   assign span_ext = CMPW'(1) << SAMPLE_BITS;
   assign lc_eff   = (lc_ext == '0) ? DW'(1) :
                     (lc_ext > span_ext) ? DW'(span_ext) : DW'(lc_ext);

   assign div_start    = cmd.start_inc | cmd.start_pos;
   assign div_dividend = cmd.start_inc ? DW'(span_ext) : DW'(s_ff);
   assign div_divisor  = cmd.start_inc ? lc_eff : inc_ff;

   pciq_div #(.WIDTH(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign pos     = (div_quot >= lc_eff) ? lc_eff - 1'b1 : div_quot;
   assign pos16   = VALUE_BITS'(pos);
   assign quarter = inc_ff >> 2;

   assign press     = s_ff < HALF;
   assign release_s = s_ff > HALF;

   assign status.need_div  = (mode_ff == MODE_POT) || (mode_ff == MODE_SEL);
   assign status.inc_valid = inc_valid_ff;
   assign status.div_done  = div_done;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_if.ready;

   always_comb begin
      logic [STABLE_BITS-1:0] bumped;
      logic [VALUE_BITS:0]    tap_next;
      logic [VALUE_BITS-1:0]  tap_new;
      logic [VALUE_BITS-1:0]  tap_clamped;
      logic [VALUE_BITS-1:0]  level;

      bumped      = (stable_ff == '1) ? stable_ff : stable_ff + 1'b1;
      tap_next    = {1'b0, tap_ff} + (VALUE_BITS + 1)'(1);
      tap_new     = tap_next[VALUE_BITS-1:0];
      tap_clamped = (tap_new < tempo_min_ff) ? tempo_min_ff : tap_new;
      level       = VALUE_BITS'(press);

      cv_in      = cv_ff;
      phase_in   = phase_ff;
      stable_in  = stable_ff;
      tap_in     = tap_ff;
      unsaved_in = unsaved_ff;
      changed_in = 1'b0;
      led_in     = LED_NONE;
      off_in     = '0;
      warm_in    = (warm_ff < WARM_LIMIT) ? warm_ff + 1'b1 : warm_ff;

      if (warm_in >= WARM_LIMIT) begin
         case (mode_ff)
            MODE_POT: begin
               if ((pos16 > cv_ff && (pos16 - cv_ff > 16'd1 || div_rem > quarter)) ||
                   (pos16 < cv_ff && (cv_ff - pos16 > 16'd1 || div_rem < inc_ff - quarter))) begin
                  cv_in      = pos16;
                  changed_in = 1'b1;
               end
            end
            MODE_SEL: begin
               if (pos16 != cv_ff) begin
                  cv_in      = pos16;
                  changed_in = 1'b1;
               end
            end
            MODE_TOGGLE: begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (press) begin
                        phase_in  = PH_DOWN;
                        stable_in = '0;
                     end
                  end
                  PH_DOWN: begin
                     if (press) begin
                        stable_in = bumped;
                        if (bumped > STABLE_BUTTON) begin
                           cv_in      = (cv_ff == '0) ? VALUE_BITS'(1) : '0;
                           changed_in = 1'b1;
                           unsaved_in = 1'b1;
                           phase_in   = PH_HELD;
                        end
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_HELD: begin
                     if (release_s) begin
                        phase_in  = PH_ARMED;
                        stable_in = '0;
                     end
                  end
                  PH_ARMED: begin
                     if (release_s) begin
                        stable_in = bumped;
                        if (bumped > STABLE_BUTTON) begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        phase_in = PH_HELD;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            MODE_MOM: begin
               if (cv_ff == level) begin
                  stable_in = '0;
               end else begin
                  stable_in = bumped;
                  if (bumped > STABLE_BUTTON) begin
                     cv_in      = level;
                     changed_in = 1'b1;
                  end
               end
            end
            MODE_TAP: begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (press) begin
                        phase_in = PH_DOWN;
                        tap_in   = '0;
                        led_in   = LED_ON;
                     end
                  end
                  PH_DOWN, PH_HELD, PH_ARMED: begin
                     if (tap_next > {1'b0, tempo_max_ff}) begin
                        // measurement expired: blink the held tempo
                        led_in   = LED_BLINK;
                        off_in   = off_time(cv_ff);
                        phase_in = PH_IDLE;
                     end else begin
                        tap_in = tap_new;
                        case (phase_ff)
                           PH_DOWN: begin
                              if (release_s) begin
                                 phase_in  = PH_HELD;
                                 stable_in = '0;
                              end
                           end
                           PH_HELD: begin
                              if (release_s) begin
                                 stable_in = bumped;
                                 if (bumped > STABLE_TAP) begin
                                    phase_in = PH_ARMED;
                                 end
                              end else begin
                                 stable_in = '0;
                              end
                           end
                           default: begin
                              if (press) begin
                                 tap_in     = tap_clamped;
                                 led_in     = LED_BLINK;
                                 off_in     = off_time(tap_clamped);
                                 cv_in      = tap_clamped;
                                 changed_in = 1'b1;
                                 stable_in  = '0;
                                 phase_in   = PH_SETTLE;
                              end
                           end
                        endcase
                     end
                  end
                  PH_SETTLE: begin
                     if (release_s) begin
                        stable_in = bumped;
                        if (bumped > STABLE_TAP) begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        stable_in = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         levels_ff    <= LEVEL_BITS'(1);
         inverted_ff  <= 1'b0;
         tempo_min_ff <= '0;
         tempo_max_ff <= '1;
         inc_valid_ff <= 1'b0;
         cv_ff        <= '0;
         phase_ff     <= PH_IDLE;
         stable_ff    <= '0;
         tap_ff       <= '0;
         warm_ff      <= '0;
         unsaved_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_if.index)
               CSR_MODE:      mode_ff      <= csr_if.data[MODE_BITS-1:0];
               CSR_LEVELS:    levels_ff    <= csr_if.data[LEVEL_BITS-1:0];
               CSR_INVERTED:  inverted_ff  <= csr_if.data[0];
               CSR_TEMPO_MIN: tempo_min_ff <= csr_if.data;
               CSR_TEMPO_MAX: tempo_max_ff <= csr_if.data;
               default: begin
               end
            endcase
         end
         // step width follows level_count; recompute after a write
         if (csr_write && csr_if.index == CSR_LEVELS) begin
            inc_valid_ff <= 1'b0;
         end else if (cmd.latch_inc) begin
            inc_valid_ff <= 1'b1;
         end
         if (cmd.update) begin
            cv_ff      <= cv_in;
            phase_ff   <= phase_in;
            stable_ff  <= stable_in;
            tap_ff     <= tap_in;
            warm_ff    <= warm_in;
            unsaved_ff <= unsaved_in;
         end
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_sample) begin
         s_ff <= inverted_ff ? ~req_sample : req_sample;
      end
      if (cmd.latch_inc) begin
         inc_ff <= div_quot;
      end
      if (cmd.update) begin
         rsp_value_ff   <= cv_in;
         rsp_changed_ff <= changed_in;
         rsp_unsaved_ff <= unsaved_in;
         rsp_led_ff     <= led_in;
         rsp_off_ff     <= off_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.value           = rsp_value_ff;
   assign rsp_if.changed         = rsp_changed_ff;
   assign rsp_if.unsaved_changes = rsp_unsaved_ff;
   assign rsp_if.led_action      = rsp_led_ff;
   assign rsp_if.led_off_time    = rsp_off_ff;

   a_off_only_on_blink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_led_ff != LED_BLINK |-> rsp_off_ff == '0)
      else $error("led_off_time set without a blink command");

   a_unsaved_sticky: assert property (@(posedge clock) disable iff (reset)
      unsaved_ff |=> unsaved_ff)
      else $error("unsaved flag cleared without reset");

   a_pos_div_has_step: assert property (@(posedge clock) disable iff (reset)
      cmd.start_pos |-> inc_valid_ff)
      else $error("level division started without a valid step width");

endmodule

// ----- rtl/core/pciq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pciq_ctrl
// Sequencer: accepts a sample, runs the level division (the step-width one
// first if stale) when the mode quantizes, then updates the result register.
// ----------------------------------------------------------------------------
module pciq_ctrl import pciq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  pciq_status_type status,
   output pciq_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_INC_DIV   = 3'd2;
   localparam logic [2:0] S_INC_LATCH = 3'd3;
   localparam logic [2:0] S_POS_DIV   = 3'd4;
   localparam logic [2:0] S_UPDATE    = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!status.need_div) begin
               state_in = S_UPDATE;
            end else if (status.inc_valid) begin
               cmd.start_pos = 1'b1;
               state_in      = S_POS_DIV;
            end else begin
               cmd.start_inc = 1'b1;
               state_in      = S_INC_DIV;
            end
         end
         S_INC_DIV: begin
            if (status.div_done) begin
               state_in = S_INC_LATCH;
            end
         end
         S_INC_LATCH: begin
            cmd.latch_inc = 1'b1;
            state_in      = S_DISPATCH;
         end
         S_POS_DIV: begin
            if (status.div_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold while the previous transaction still waits at the output
            if (!status.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/pedal_control_input_qualifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_control_input_qualifier_unit
// Qualifies one control channel per sample tick: pot/selector quantizing,
// debounced toggle and momentary buttons, and tap tempo with LED commands.
// ----------------------------------------------------------------------------
// One sample at a time. In pot and selector modes a sample passes through
// accept, dispatch, SAMPLE_BITS+1 steps of the shared restoring divider
// that finds the level, and the update into the result register. The
// first such sample after reset or after a level_count write runs the
// divider once more beforehand to find and latch the step width. Button,
// tap and disabled modes pass through accept, dispatch and update. A
// result may wait at the output while the next sample is accepted; the
// update of that sample then holds until the result is taken.
// Register writes complete in the cycle they are presented.
module pedal_control_input_qualifier_unit import pciq_pkg::*; #(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int WARMUP_TICKS = WARMUP_TICKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pciq_req_if.sink   req_if,
   pciq_rsp_if.source rsp_if,
   pciq_csr_if.sink   csr_if
);

   pciq_cmd_type    cmd;
   pciq_status_type status;

   pciq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pciq_datapath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .WARMUP_TICKS (WARMUP_TICKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_if.sample),
      .cmd        (cmd),
      .status     (status),
      .csr_if     (csr_if),
      .rsp_if     (rsp_if)
   );

endmodule
